// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// trigger implies a condition in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// ===== src/kmlau_pkg.sv =====
// shared types, codes and constants of the k-means assign and update block
// no dependencies
package kmlau_pkg;

   localparam int NUM_CENTERS_DEF = 8;
   localparam int NUM_DIMS_DEF    = 4;
   localparam int COUNT_BITS_DEF  = 21;

   localparam int COORD_W      = 16;
   localparam int CENTERS_REG_W = 4;
   localparam int DIMS_REG_W    = 3;
   localparam int COST_W        = 64;
   localparam int NDIST_W       = 36;
   localparam int NIDX_W        = 3;
   localparam int CONV_TERMS    = 5;
   localparam int CONV_W        = COST_W + 14;

   localparam logic [0:0] REG_CENTERS = 1'b0;
   localparam logic [0:0] REG_DIMS    = 1'b1;

   typedef enum logic [1:0] {
      OP_CENTER = 2'd0,
      OP_POINT  = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef enum logic {
      KIND_ASSIGN  = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic mul;
      logic acc;
      logic clr_point;
      logic assign_pt;
      logic div_start;
      logic clr_acc;
   } cell_cmd_type;

   typedef struct packed {
      logic busy;
      logic cnt_zero;
   } cell_stat_type;

   typedef struct packed {
      logic                empty;
      logic                conv;
      logic [COST_W-1:0]   cost;
      logic [NDIST_W-1:0]  distance;
      logic [NIDX_W-1:0]   idx;
      kind_type            kind;
   } result_type;

   function automatic int clamp_reg(input int v, input int top);
      int r;
      r = v;
      if (v == 0) r = 1;
      else if (v > top) r = top;
      return r;
   endfunction

   // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
   function automatic int conv_shift(input logic [2:0] k);
      int s;
      case (k)
         3'd0: s = 13;
         3'd1: s = 10;
         3'd2: s = 9;
         3'd3: s = 8;
         3'd4: s = 4;
         default: s = 0;
      endcase
      return s;
   endfunction

endpackage

// ===== src/kmlau_cell.sv =====
// one center cell: coordinates, partial distance, cluster sums, argmin token stage
// and a restoring divider for the mean; depends on kmlau_pkg
module kmlau_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int NUM_CENTERS = kmlau_pkg::NUM_CENTERS_DEF,
   parameter int NUM_DIMS    = kmlau_pkg::NUM_DIMS_DEF,
   parameter int COUNT_BITS  = kmlau_pkg::COUNT_BITS_DEF,
   localparam int DIM_IDX_BITS = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1,
   localparam int CIDX_BITS    = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1,
   localparam int DIST_BITS    = 34 + $clog2(NUM_DIMS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kmlau_pkg::cell_cmd_type             cmd,
   input  logic                                in_use,
   input  logic [NUM_DIMS-1:0]                 dim_use,
   input  logic                                wr_en,
   input  logic [DIM_IDX_BITS-1:0]             wr_dim,
   input  logic signed [kmlau_pkg::COORD_W-1:0] wr_value,
   input  logic [DIM_IDX_BITS-1:0]             pt_dim,
   input  logic signed [kmlau_pkg::COORD_W-1:0] pt_value,
   input  logic signed [kmlau_pkg::COORD_W-1:0] pt_buf [NUM_DIMS],
   input  logic [NUM_DIMS-1:0]                 pt_mask,
   input  logic [CIDX_BITS-1:0]                win_idx,
   input  logic                                tok_valid_in,
   input  logic [CIDX_BITS-1:0]                tok_idx_in,
   input  logic [DIST_BITS-1:0]                tok_dist_in,
   output logic                                tok_valid_out,
   output logic [CIDX_BITS-1:0]                tok_idx_out,
   output logic [DIST_BITS-1:0]                tok_dist_out,
   output kmlau_pkg::cell_stat_type            stat
);

   localparam int CW       = kmlau_pkg::COORD_W;
   localparam int SUM_BITS = CW + COUNT_BITS;
   localparam int BIT_W    = $clog2(SUM_BITS);

   logic signed [CW-1:0]       center_ff [NUM_DIMS];
   logic signed [CW-1:0]       center_in [NUM_DIMS];
   logic signed [SUM_BITS-1:0] sum_ff    [NUM_DIMS];
   logic signed [SUM_BITS-1:0] sum_in    [NUM_DIMS];
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [DIST_BITS-1:0]       partial_ff, partial_in;
   logic [33:0]                prod_ff;
   logic                       tok_valid_ff;
   logic [CIDX_BITS-1:0]       tok_idx_ff;
   logic [DIST_BITS-1:0]       tok_dist_ff;

   logic                       busy_ff;
   logic [DIM_IDX_BITS-1:0]    dim_ff;
   logic [BIT_W-1:0]           bit_ff;
   logic [SUM_BITS-1:0]        quo_ff;
   logic [COUNT_BITS-1:0]      rem_ff;
   logic                       neg_ff;

   logic signed [CW:0]         diff;
   logic signed [2*CW+1:0]     sq;
   logic                       take, win, last_bit, last_dim, write_ok;
   logic [COUNT_BITS:0]        rem_sh;
   logic                       ge;
   logic [COUNT_BITS-1:0]      rem_nx;
   logic [SUM_BITS-1:0]        q_nx, q_signed;
   logic [DIM_IDX_BITS-1:0]    load_dim;
   logic signed [SUM_BITS-1:0] load_sum;
   logic [SUM_BITS-1:0]        load_mag;

   // distance term and argmin stage
   always_comb begin
      diff = (CW+1)'(pt_value) - (CW+1)'(center_ff[pt_dim]);
      sq   = diff * diff;
      take = tok_valid_in && in_use && ((CELL_INDEX == 0) || (partial_ff < tok_dist_in));
      if (cmd.clr_point) partial_in = '0;
      else if (cmd.acc) partial_in = partial_ff + DIST_BITS'(prod_ff);
      else partial_in = partial_ff;
   end

   // divider step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUM_BITS-1]};
      ge       = rem_sh >= {1'b0, count_ff};
      rem_nx   = ge ? COUNT_BITS'(rem_sh - {1'b0, count_ff}) : COUNT_BITS'(rem_sh);
      q_nx     = {quo_ff[SUM_BITS-2:0], ge};
      q_signed = neg_ff ? (~q_nx + 1'b1) : q_nx;
      last_bit = bit_ff == BIT_W'(SUM_BITS - 1);
      last_dim = dim_ff == DIM_IDX_BITS'(NUM_DIMS - 1);
      write_ok = in_use && (count_ff != '0) && dim_use[dim_ff];
      load_dim = cmd.div_start ? '0 : DIM_IDX_BITS'(dim_ff + 1'b1);
      load_sum = sum_ff[load_dim];
      load_mag = load_sum[SUM_BITS-1] ? SUM_BITS'(-load_sum) : SUM_BITS'(load_sum);
   end

   // centers, sums and count
   always_comb begin
      win = cmd.assign_pt && (win_idx == CIDX_BITS'(CELL_INDEX)) && (count_ff != '1);
      center_in = center_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (wr_en) center_in[wr_dim] = wr_value;
      if (busy_ff && last_bit && write_ok) center_in[dim_ff] = q_signed[CW-1:0];
      if (cmd.clr_acc) begin
         count_in = '0;
         for (int d = 0; d < NUM_DIMS; d++) sum_in[d] = '0;
      end else if (win) begin
         count_in = count_ff + 1'b1;
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (pt_mask[d]) sum_in[d] = sum_ff[d] + SUM_BITS'(pt_buf[d]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            center_ff[d] <= '0;
            sum_ff[d]    <= '0;
         end
         count_ff     <= '0;
         partial_ff   <= '0;
         tok_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         center_ff    <= center_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         partial_ff   <= partial_in;
         tok_valid_ff <= tok_valid_in;
         if (cmd.div_start) busy_ff <= 1'b1;
         else if (busy_ff && last_bit && last_dim) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= 34'(sq);
      tok_idx_ff  <= take ? CIDX_BITS'(CELL_INDEX) : tok_idx_in;
      tok_dist_ff <= take ? partial_ff : tok_dist_in;
      if (cmd.div_start || (busy_ff && last_bit)) begin
         dim_ff <= load_dim;
         bit_ff <= '0;
         rem_ff <= '0;
         quo_ff <= load_mag;
         neg_ff <= load_sum[SUM_BITS-1];
      end else if (busy_ff) begin
         bit_ff <= bit_ff + 1'b1;
         rem_ff <= rem_nx;
         quo_ff <= q_nx;
      end
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_idx_out   = tok_idx_ff;
   assign tok_dist_out  = tok_dist_ff;
   assign stat.busy     = busy_ff;
   assign stat.cnt_zero = (count_ff == '0);

endmodule

// ===== src/kmeans_lloyd_assign_update.sv =====
// top level of the k-means assign and update block: control, chain of center cells
// depends on kmlau_pkg, kmlau_cell and assert_macros.svh
//
// channel  direction  transfer when          contents
// req      in         req_tvalid & tready    tuser operation, tlast last coordinate, tdata
// rsp      out        rsp_tvalid & tready    tuser result kind, tdata results
// csr      in         csr_we                 register index and value
//
// a center write is taken in the idle state; a point coordinate is squared, then
// accumulated, and after the last one the argmin token runs down the cell chain to emit
// pass end waits on the restoring divider in each cell, which runs one quotient
// bit per cycle
// reset clears control, cost and cell state with no clearing pass; the point buffer
// is written before it is read
// a result waits in the output register; a new result waits until it is taken
`include "assert_macros.svh"
module kmeans_lloyd_assign_update #(
   parameter int NUM_CENTERS = kmlau_pkg::NUM_CENTERS_DEF,
   parameter int NUM_DIMS    = kmlau_pkg::NUM_DIMS_DEF,
   parameter int COUNT_BITS  = kmlau_pkg::COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // center_index, coord_index, coord_value, zero fill
   input  logic [1:0]   req_tuser,   // operation
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // nearest_center, nearest_distance, pass_cost,
                                     // converged, empty_cluster, zero fill
   output logic         rsp_tuser,   // result_kind
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [3:0]   csr_wdata
);

   localparam int CW           = kmlau_pkg::COORD_W;
   localparam int DIM_IDX_BITS = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int CIDX_BITS    = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
   localparam int DIST_BITS    = 34 + $clog2(NUM_DIMS);
   localparam int CNT_BITS     = $clog2(NUM_DIMS + 1);
   localparam int COST_W       = kmlau_pkg::COST_W;
   localparam int CONV_W       = kmlau_pkg::CONV_W;

   kmlau_pkg::state_type  state_ff, state_in;
   kmlau_pkg::cell_cmd_type cmd;
   kmlau_pkg::cell_stat_type stat [NUM_CENTERS];
   kmlau_pkg::op_type     op;
   kmlau_pkg::result_type pend_ff, rsp_ff;

   logic [kmlau_pkg::CENTERS_REG_W-1:0] centers_ff;
   logic [kmlau_pkg::DIMS_REG_W-1:0]    dims_ff;
   int                          nc_eff, nd_eff;
   logic [NUM_CENTERS-1:0]      in_use, wr_en, cnt_zero, busy;
   logic [NUM_DIMS-1:0]         dim_use, pt_mask;

   logic [2:0]                  ci;
   logic [1:0]                  di;
   logic signed [CW-1:0]        cv;
   logic                        accept, pt_end;
   logic [CNT_BITS-1:0]         cc_ff, cc_next;
   logic signed [CW-1:0]        pt_buf_ff [NUM_DIMS];
   logic                        end_ff, start_ff;

   logic                        tok_v [NUM_CENTERS+1];
   logic [CIDX_BITS-1:0]        tok_i [NUM_CENTERS+1];
   logic [DIST_BITS-1:0]        tok_d [NUM_CENTERS+1];

   logic [COST_W-1:0]           cost_ff, prev_ff, cost_new, diff_ff;
   logic [COST_W:0]             cost_sum;
   logic [CONV_W-1:0]           acc_ff;
   logic [2:0]                  k_ff;
   logic                        conv_done, conv, empty, emit_load;

   assign ci     = req_tdata[2:0];
   assign di     = req_tdata[4:3];
   assign cv     = req_tdata[20:5];
   assign op     = kmlau_pkg::op_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   assign nc_eff = kmlau_pkg::clamp_reg(int'(centers_ff), NUM_CENTERS);
   assign nd_eff = kmlau_pkg::clamp_reg(int'(dims_ff), NUM_DIMS);

   always_comb begin
      for (int i = 0; i < NUM_CENTERS; i++) begin
         in_use[i]   = i < nc_eff;
         wr_en[i]    = accept && (op == kmlau_pkg::OP_CENTER) && (int'(di) < NUM_DIMS)
                       && (int'(ci) == i);
         cnt_zero[i] = stat[i].cnt_zero;
         busy[i]     = stat[i].busy;
      end
      for (int d = 0; d < NUM_DIMS; d++) begin
         dim_use[d] = d < nd_eff;
         pt_mask[d] = d < int'(cc_ff);
      end
   end

   assign cc_next = cc_ff + 1'b1;
   assign pt_end  = req_tlast || (int'(cc_next) >= nd_eff);

   assign tok_v[0] = start_ff;
   assign tok_i[0] = '0;
   assign tok_d[0] = '0;

   for (genvar g = 0; g < NUM_CENTERS; g++) begin : g_cell
      kmlau_cell #(
         .CELL_INDEX  (g),
         .NUM_CENTERS (NUM_CENTERS),
         .NUM_DIMS    (NUM_DIMS),
         .COUNT_BITS  (COUNT_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .in_use        (in_use[g]),
         .dim_use       (dim_use),
         .wr_en         (wr_en[g]),
         .wr_dim        (DIM_IDX_BITS'(di)),
         .wr_value      (cv),
         .pt_dim        (cc_ff[DIM_IDX_BITS-1:0]),
         .pt_value      (cv),
         .pt_buf        (pt_buf_ff),
         .pt_mask       (pt_mask),
         .win_idx       (tok_i[NUM_CENTERS]),
         .tok_valid_in  (tok_v[g]),
         .tok_idx_in    (tok_i[g]),
         .tok_dist_in   (tok_d[g]),
         .tok_valid_out (tok_v[g+1]),
         .tok_idx_out   (tok_i[g+1]),
         .tok_dist_out  (tok_d[g+1]),
         .stat          (stat[g])
      );
   end

   // cost, convergence and empty check
   always_comb begin
      cost_sum  = {1'b0, cost_ff} + (COST_W+1)'(tok_d[NUM_CENTERS]);
      cost_new  = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
      conv_done = k_ff == 3'(kmlau_pkg::CONV_TERMS);
      if (cost_ff > prev_ff) conv = 1'b1;
      else if (cost_ff == prev_ff) conv = prev_ff != '0;
      else conv = acc_ff < CONV_W'(prev_ff);
      empty     = |(in_use & cnt_zero);
      emit_load = (state_ff == kmlau_pkg::ST_EMIT) && (!rsp_tvalid || rsp_tready);
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         kmlau_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (op)
                  kmlau_pkg::OP_POINT: begin
                     cmd.mul  = 1'b1;
                     state_in = kmlau_pkg::ST_ACC;
                  end
                  kmlau_pkg::OP_FINISH: begin
                     cmd.div_start = 1'b1;
                     cmd.clr_point = 1'b1;
                     state_in      = kmlau_pkg::ST_DIV;
                  end
                  default: state_in = kmlau_pkg::ST_IDLE;
               endcase
            end
         end
         kmlau_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = end_ff ? kmlau_pkg::ST_SCAN : kmlau_pkg::ST_IDLE;
         end
         kmlau_pkg::ST_SCAN: begin
            if (tok_v[NUM_CENTERS]) begin
               cmd.assign_pt = 1'b1;
               cmd.clr_point = 1'b1;
               state_in      = kmlau_pkg::ST_EMIT;
            end
         end
         kmlau_pkg::ST_DIV: begin
            if (!(|busy) && conv_done) begin
               cmd.clr_acc = 1'b1;
               state_in    = kmlau_pkg::ST_EMIT;
            end
         end
         kmlau_pkg::ST_EMIT: begin
            if (!rsp_tvalid || rsp_tready) state_in = kmlau_pkg::ST_IDLE;
         end
         default: state_in = kmlau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kmlau_pkg::ST_IDLE;
         centers_ff <= 4'd8;
         dims_ff    <= 3'd4;
         cc_ff      <= '0;
         end_ff     <= 1'b0;
         start_ff   <= 1'b0;
         cost_ff    <= '0;
         prev_ff    <= '1;
         k_ff       <= 3'(kmlau_pkg::CONV_TERMS);
         rsp_tvalid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               kmlau_pkg::REG_CENTERS: centers_ff <= csr_wdata;
               kmlau_pkg::REG_DIMS:    dims_ff    <= csr_wdata[2:0];
               default: ;
            endcase
         end
         start_ff <= (state_ff == kmlau_pkg::ST_ACC) && end_ff;
         if (accept && (op == kmlau_pkg::OP_POINT)) begin
            end_ff <= pt_end;
            cc_ff  <= cc_next;
         end
         if (cmd.clr_point) cc_ff <= '0;
         if (cmd.assign_pt) cost_ff <= cost_new;
         if (accept && (op == kmlau_pkg::OP_FINISH)) k_ff <= '0;
         else if ((state_ff == kmlau_pkg::ST_DIV) && !conv_done) k_ff <= k_ff + 1'b1;
         if (cmd.clr_acc) begin
            prev_ff <= cost_ff;
            cost_ff <= '0;
         end
         if (emit_load) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (op == kmlau_pkg::OP_POINT)) pt_buf_ff[cc_ff[DIM_IDX_BITS-1:0]] <= cv;
      if (accept && (op == kmlau_pkg::OP_FINISH)) begin
         diff_ff <= prev_ff - cost_ff;
         acc_ff  <= '0;
      end else if ((state_ff == kmlau_pkg::ST_DIV) && !conv_done) begin
         acc_ff <= acc_ff + (CONV_W'(diff_ff) << kmlau_pkg::conv_shift(k_ff));
      end
      if (cmd.assign_pt) begin
         pend_ff.kind     <= kmlau_pkg::KIND_ASSIGN;
         pend_ff.idx      <= kmlau_pkg::NIDX_W'(tok_i[NUM_CENTERS]);
         pend_ff.distance <= kmlau_pkg::NDIST_W'(tok_d[NUM_CENTERS]);
         pend_ff.cost     <= cost_new;
         pend_ff.conv     <= 1'b0;
         pend_ff.empty    <= 1'b0;
      end
      if (cmd.clr_acc) begin
         pend_ff.kind     <= kmlau_pkg::KIND_SUMMARY;
         pend_ff.idx      <= '0;
         pend_ff.distance <= '0;
         pend_ff.cost     <= cost_ff;
         pend_ff.conv     <= conv;
         pend_ff.empty    <= empty;
      end
      if (emit_load) rsp_ff <= pend_ff;
   end

   assign rsp_tuser = rsp_ff.kind;
   assign rsp_tdata = {7'b0, rsp_ff.empty, rsp_ff.conv, rsp_ff.cost, rsp_ff.distance,
                       rsp_ff.idx};

   `ASSERT_ALWAYS(a_no_token_in_div, clock, reset,
      !((state_ff == kmlau_pkg::ST_DIV) && tok_v[NUM_CENTERS]))
   `ASSERT_NEXT(a_cost_grows, clock, reset, cmd.assign_pt, cost_ff >= $past(cost_ff))
   `ASSERT_NEXT(a_emit_loads, clock, reset, emit_load, rsp_tvalid)
   `ASSERT_ALWAYS(a_cells_idle_outside_div, clock, reset,
      !((state_ff == kmlau_pkg::ST_SCAN) && (|busy)))

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the k-means assign and update block: directed and random passes
// checked transfer by transfer against a behavioral predictor of the pass
// depends on kmlau_pkg and the kmeans_lloyd_assign_update rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NC = kmlau_pkg::NUM_CENTERS_DEF;
   localparam int ND = kmlau_pkg::NUM_DIMS_DEF;
   localparam int SETTLE = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_addr = '0;
   logic [3:0]   csr_wdata = '0;

   kmeans_lloyd_assign_update u_top (.*);

   // predictor state
   int               center_val [NC][ND];
   int               point_coord [ND];
   int               coord_cnt;
   longint unsigned  part_dist [NC];
   longint           sum_acc [NC][ND];
   longint unsigned  count_acc [NC];
   longint unsigned  run_cost;
   longint unsigned  cost_before;
   int               centers_reg;
   int               dims_reg;

   kmlau_pkg::result_type expected_q [$];
   int               mismatches = 0;
   int               gap_mode = 1;
   int               rsp_hold = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #10ms;
      $display("tb_top: errors");
      $finish;
   end

   function automatic int clamp_to(input int v, input int top);
      return (v == 0) ? 1 : ((v > top) ? top : v);
   endfunction

   function automatic void clear_pass();
      for (int c = 0; c < NC; c++) begin
         count_acc[c] = 0;
         part_dist[c] = 0;
         for (int d = 0; d < ND; d++) sum_acc[c][d] = 0;
      end
      run_cost = 0;
      coord_cnt = 0;
   endfunction

   function automatic void predict_item(input logic [1:0] op, input logic [2:0] ci,
                                        input logic [1:0] di, input logic [15:0] val,
                                        input logic last);
      kmlau_pkg::result_type r;
      int nc, nd, best, v;
      longint unsigned bestd, diff2;
      longint diff;
      logic conv, empty;
      nc = clamp_to(centers_reg, NC);
      nd = clamp_to(dims_reg, ND);
      v = $signed(val);
      r = '0;
      if (op == kmlau_pkg::OP_CENTER) begin
         center_val[ci][di] = v;
      end else if (op == kmlau_pkg::OP_POINT) begin
         point_coord[coord_cnt] = v;
         for (int c = 0; c < NC; c++) begin
            diff = longint'(v) - longint'(center_val[c][coord_cnt]);
            diff2 = diff * diff;
            part_dist[c] += diff2;
         end
         coord_cnt++;
         if (last || coord_cnt >= nd) begin
            best = 0;
            bestd = part_dist[0];
            for (int c = 1; c < nc; c++)
               if (part_dist[c] < bestd) begin
                  bestd = part_dist[c];
                  best = c;
               end
            run_cost = (run_cost > ~64'd0 - bestd) ? ~64'd0 : run_cost + bestd;
            if (count_acc[best] < (64'd1 << kmlau_pkg::COUNT_BITS_DEF) - 1) begin
               count_acc[best]++;
               for (int d = 0; d < coord_cnt; d++) sum_acc[best][d] += point_coord[d];
            end
            r.kind = kmlau_pkg::KIND_ASSIGN;
            r.idx = best[2:0];
            r.distance = bestd[35:0];
            r.cost = run_cost;
            expected_q.insert(expected_q.size(), r);
            coord_cnt = 0;
            for (int c = 0; c < NC; c++) part_dist[c] = 0;
         end
      end else if (op == kmlau_pkg::OP_FINISH) begin
         empty = 1'b0;
         for (int c = 0; c < nc; c++) begin
            if (count_acc[c] == 0) empty = 1'b1;
            else
               for (int d = 0; d < nd; d++)
                  center_val[c][d] = int'(sum_acc[c][d] / longint'(count_acc[c]));
         end
         if (run_cost > cost_before) conv = 1'b1;
         else if (run_cost == cost_before) conv = (cost_before != 0);
         else conv = (cost_before - run_cost) <= (cost_before - 1) / 10000;
         r.kind = kmlau_pkg::KIND_SUMMARY;
         r.cost = run_cost;
         r.conv = conv;
         r.empty = empty;
         expected_q.insert(expected_q.size(), r);
         cost_before = run_cost;
         clear_pass();
      end
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (gap_mode == 0 || p < 60) return 0;
      if (p < 96) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [2:0] ci,
                            input logic [1:0] di, input logic [15:0] val,
                            input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tlast  <= last;
      req_tdata  <= {3'b000, val, di, ci};
      do @(posedge clock); while (!req_tready);
      predict_item(op, ci, di, val, last);
   endtask

   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      if (idx == kmlau_pkg::REG_CENTERS) centers_reg = val;
      else dims_reg = val & 3'h7;
   endtask

   task automatic send_point(input int len, input logic early);
      for (int d = 0; d < len; d++)
         send_item(kmlau_pkg::OP_POINT, 3'($urandom), 2'($urandom), rand_coord(),
                   (d == len - 1) && early);
   endtask

   // result checking
   always @(posedge clock) begin
      kmlau_pkg::result_type want;
      kmlau_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind     = kmlau_pkg::kind_type'(rsp_tuser);
         got.idx      = rsp_tdata[2:0];
         got.distance = rsp_tdata[38:3];
         got.cost     = rsp_tdata[102:39];
         got.conv     = rsp_tdata[103];
         got.empty    = rsp_tdata[104];
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %p", got);
         end else begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.idx !== want.idx ||
                got.distance !== want.distance ||
                got.cost !== want.cost || got.conv !== want.conv ||
                got.empty !== want.empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // mostly short stalls, now and then a long one; no stalls when gap_mode is 0
   always @(negedge clock) begin
      if (gap_mode == 0) rsp_tready <= 1'b1;
      else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_hold = $urandom_range(20, 60);
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(0, 99) < 70);
   end

   task automatic test_directed();
      for (int c = 0; c < NC; c++)
         for (int d = 0; d < ND; d++)
            send_item(kmlau_pkg::OP_CENTER, c[2:0], d[1:0],
                      (c % 2) ? 16'h7fff : 16'h8000, 1'b0);
      send_point(ND, 1'b0);
      send_item(kmlau_pkg::OP_POINT, 3'd0, 2'd0, 16'h7fff, 1'b0);
      send_item(kmlau_pkg::OP_POINT, 3'd0, 2'd0, 16'h8000, 1'b1);
      // pass end drops the open point
      send_item(kmlau_pkg::OP_POINT, 3'd0, 2'd0, 16'h0001, 1'b0);
      send_item(OP_UNUSED, 3'd7, 2'd3, 16'hffff, 1'b1);
      send_item(kmlau_pkg::OP_FINISH, 3'd0, 2'd0, 16'h0000, 1'b0);
      // zero cost below previous, then zero equal to previous
      send_item(kmlau_pkg::OP_FINISH, 3'd0, 2'd0, 16'h0000, 1'b0);
      send_item(kmlau_pkg::OP_FINISH, 3'd0, 2'd0, 16'h0000, 1'b0);
      drain();
   endtask

   task automatic test_config_extremes();
      write_reg(kmlau_pkg::REG_CENTERS, 4'd0);
      write_reg(kmlau_pkg::REG_DIMS, 4'd0);
      repeat (4) send_point(1, 1'b0);
      send_item(kmlau_pkg::OP_FINISH, 3'd0, 2'd0, 16'h0, 1'b0);
      drain();
      write_reg(kmlau_pkg::REG_CENTERS, 4'd15);
      write_reg(kmlau_pkg::REG_DIMS, 4'd7);
      repeat (4) send_point(ND, 1'b0);
      send_item(kmlau_pkg::OP_FINISH, 3'd0, 2'd0, 16'h0, 1'b0);
      drain();
   endtask

   task automatic test_random_passes();
      int items;
      int npts;
      int plen;
      items = 0;
      while (items < 500) begin
         gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
         write_reg(kmlau_pkg::REG_CENTERS, 4'($urandom_range(0, 15)));
         write_reg(kmlau_pkg::REG_DIMS, 4'($urandom_range(0, 7)));
         for (int p = 0; p < 3; p++) begin
            for (int k = $urandom_range(0, 6); k > 0; k--) begin
               send_item(kmlau_pkg::OP_CENTER, 3'($urandom), 2'($urandom), rand_coord(),
                         1'($urandom));
               items++;
            end
            npts = $urandom_range(2, 12);
            for (int n = 0; n < npts; n++) begin
               case ($urandom_range(0, 9))
                  0: begin
                     send_item(OP_UNUSED, 3'($urandom), 2'($urandom), rand_coord(),
                               1'($urandom));
                     items++;
                  end
                  1: begin
                     send_item(kmlau_pkg::OP_CENTER, 3'($urandom), 2'($urandom),
                               rand_coord(), 1'b0);
                     items++;
                  end
                  default: ;
               endcase
               plen = $urandom_range(1, ND);
               send_point(plen, 1'($urandom));
               items += plen;
            end
            if ($urandom_range(0, 4) == 0) begin
               send_point(1, 1'b0);
               items++;
            end
            send_item(kmlau_pkg::OP_FINISH, 3'($urandom), 2'($urandom), rand_coord(),
                      1'($urandom));
            items++;
            // repeat a pass on settled centers to exercise convergence
            if ($urandom_range(0, 2) == 0) p--;
            if (items >= 500) break;
         end
         drain();
      end
   endtask

   initial begin
      for (int c = 0; c < NC; c++)
         for (int d = 0; d < ND; d++) center_val[c][d] = 0;
      clear_pass();
      cost_before = ~64'd0;
      centers_reg = 8;
      dims_reg = 4;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_random_passes();
      drain();
      if (mismatches == 0 && expected_q.size() == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule
